[rtl/mcr_pkg.sv]
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants and types of the midpoint circle rasterizer: default
// widths, initial difference values and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package mcr_pkg;

  // default coordinate width and fixed color width
  localparam int unsigned DefCoordBits = 12;
  localparam int unsigned ColorBits    = 24;
  localparam logic [ColorBits-1:0] ColorReset = 24'hFFFFFF;

  // eight symmetric pixels per point
  localparam int unsigned OctBits = 3;
  localparam logic [OctBits-1:0] LastOct = 3'd7;

  // action codes
  localparam logic ActStart   = 1'b0;
  localparam logic ActAdvance = 1'b1;

  // constants of the incremental differences
  localparam int DecInitBase  = 1;
  localparam int EastInit     = 3;
  localparam int SeInitBase   = 5;
  localparam int EastInc      = 2;
  localparam int SeDiagInc    = 4;

  // command from controller to datapath
  typedef struct packed {
    logic               load;  // input item accepted, update circle state
    logic               emit;  // load the output register
    logic               fin;   // emit a finished result
    logic [OctBits-1:0] oct;   // which symmetric pixel to emit
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic finish;  // the item at the input gives a finished result
  } stat_t;

endpackage

[rtl/midpoint_circle_rasterizer_core.sv]
// A taken item moves the controller to its emit state, which loads its results
// into the single output register: eight pixels for a start or an advance, one
// per cycle while the output is not stalled, or one finished result.
// The next item is taken in the cycle that issues the last result.
// Reset: asynchronous, active low; no circle active, color reads 0xFFFFFF.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core
// Integer midpoint circle rasterizer: start and advance items produce the
// eight symmetric pixels of each point, or one finished result.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_core #(
  parameter int unsigned CoordBits = mcr_pkg::DefCoordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mcr_pkg::ColorBits-1:0] cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic signed [CoordBits-1:0]   center_x_i,
  input  logic signed [CoordBits-1:0]   center_y_i,
  input  logic [CoordBits-2:0]          radius_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [CoordBits:0]     pixel_x_o,
  output logic signed [CoordBits:0]     pixel_y_o,
  output logic [mcr_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          finished_o,
  output logic                          last_o
);
  import mcr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // color register accepts a write every cycle
  assign cfg_ready_o = 1'b1;

  // sequencing
  mcr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // circle state and output item
  mcr_datapath #(
    .CoordBits (CoordBits)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_valid_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .action_i      (action_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .pixel_valid_o (pixel_valid_o),
    .finished_o    (finished_o),
    .last_o        (last_o)
  );

endmodule

[rtl/mcr_ctrl.sv]
// ----------------------------------------------------------------------------
// mcr_ctrl
// Controller of the circle rasterizer: takes one item, then issues one
// result per free output slot, eight pixels or one finished result.
// ----------------------------------------------------------------------------
module mcr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  mcr_pkg::stat_t stat_i,
  output mcr_pkg::cmd_t  cmd_o
);
  import mcr_pkg::*;

  typedef enum logic {
    StIdle,
    StEmit
  } state_e;

  state_e             state_q;
  logic [OctBits-1:0] oct_q;
  logic               fin_q;
  logic               out_valid_q;

  logic slot_free;
  logic last_emit;
  logic emit;
  logic ready;
  logic accept;

  // handshake and sequencing decisions
  assign slot_free = !out_valid_q || !out_stall_i;
  assign last_emit = fin_q || (oct_q == LastOct);
  assign emit      = (state_q == StEmit) && slot_free;
  assign ready     = (state_q == StIdle) || (emit && last_emit);
  assign accept    = in_valid_i && ready;

  assign in_stall_o  = !ready;
  assign out_valid_o = out_valid_q;

  // command to the datapath
  always_comb begin
    cmd_o.load = accept;
    cmd_o.emit = emit;
    cmd_o.fin  = fin_q;
    cmd_o.oct  = oct_q;
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      oct_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (slot_free) begin
        out_valid_q <= emit;
      end
      if (accept) begin
        state_q <= StEmit;
        oct_q   <= '0;
        fin_q   <= stat_i.finish;
      end else if (emit) begin
        if (last_emit) begin
          state_q <= StIdle;
        end else begin
          oct_q <= oct_q + OctBits'(1);
        end
      end
    end
  end

endmodule

[rtl/mcr_datapath.sv]
// ----------------------------------------------------------------------------
// mcr_datapath
// Datapath of the circle rasterizer: centre, offsets, decision value and
// its increments, the color register and the registered output item.
// ----------------------------------------------------------------------------
module mcr_datapath #(
  parameter int unsigned CoordBits = mcr_pkg::DefCoordBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mcr_pkg::cmd_t                 cmd_i,
  output mcr_pkg::stat_t                stat_o,
  input  logic                          cfg_valid_i,
  input  logic [mcr_pkg::ColorBits-1:0] cfg_data_i,
  input  logic                          action_i,
  input  logic signed [CoordBits-1:0]   center_x_i,
  input  logic signed [CoordBits-1:0]   center_y_i,
  input  logic [CoordBits-2:0]          radius_i,
  output logic signed [CoordBits:0]     pixel_x_o,
  output logic signed [CoordBits:0]     pixel_y_o,
  output logic [mcr_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          finished_o,
  output logic                          last_o
);
  import mcr_pkg::*;

  localparam int unsigned PixBits = CoordBits + 1;
  localparam int unsigned DecBits = CoordBits + 2;

  // circle state
  logic [ColorBits-1:0]        color_q;
  logic signed [CoordBits-1:0] cx_q, cy_q;
  logic [CoordBits-1:0]        col_q, row_q;
  logic signed [DecBits-1:0]   dec_q, east_q, se_q;
  logic                        busy_q;

  // output register
  logic signed [PixBits-1:0] px_q, py_q;
  logic [ColorBits-1:0]      pcol_q;
  logic                      pval_q, pfin_q, plast_q;

  logic                      finish;
  logic signed [DecBits-1:0] rad_ext;
  logic signed [PixBits-1:0] pix_x, pix_y;

  // advance finds no circle or the octant complete
  assign finish        = (action_i == ActAdvance) && (!busy_q || (col_q >= row_q));
  assign stat_o.finish = finish;
  assign rad_ext       = DecBits'(radius_i);

  // symmetric pixel selection
  always_comb begin
    logic signed [PixBits-1:0] off_a;
    logic signed [PixBits-1:0] off_b;
    off_a = cmd_i.oct[2] ? PixBits'(row_q) : PixBits'(col_q);
    off_b = cmd_i.oct[2] ? PixBits'(col_q) : PixBits'(row_q);
    pix_x = PixBits'(cx_q) + (cmd_i.oct[0] ? -off_a : off_a);
    pix_y = PixBits'(cy_q) + (cmd_i.oct[1] ? -off_b : off_b);
  end

  // color register and circle state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ColorReset;
      cx_q    <= '0;
      cy_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      dec_q   <= '0;
      east_q  <= '0;
      se_q    <= '0;
      busy_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        if (action_i == ActStart) begin
          cx_q   <= center_x_i;
          cy_q   <= center_y_i;
          col_q  <= '0;
          row_q  <= CoordBits'(radius_i);
          dec_q  <= DecBits'(DecInitBase) - rad_ext;
          east_q <= DecBits'(EastInit);
          se_q   <= DecBits'(SeInitBase) - (rad_ext <<< 1);
          busy_q <= 1'b1;
        end else if (finish) begin
          busy_q <= 1'b0;
        end else begin
          col_q  <= col_q + CoordBits'(1);
          east_q <= east_q + DecBits'(EastInc);
          if (dec_q[DecBits-1]) begin
            // step east
            dec_q <= dec_q + east_q;
            se_q  <= se_q + DecBits'(EastInc);
          end else begin
            // step south-east
            dec_q <= dec_q + se_q;
            se_q  <= se_q + DecBits'(SeDiagInc);
            row_q <= row_q - CoordBits'(1);
          end
        end
      end
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (cmd_i.fin) begin
        px_q    <= '0;
        py_q    <= '0;
        pcol_q  <= '0;
        pval_q  <= 1'b0;
        pfin_q  <= 1'b1;
        plast_q <= 1'b1;
      end else begin
        px_q    <= pix_x;
        py_q    <= pix_y;
        pcol_q  <= color_q;
        pval_q  <= 1'b1;
        pfin_q  <= 1'b0;
        plast_q <= (cmd_i.oct == LastOct);
      end
    end
  end

  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcol_q;
  assign pixel_valid_o = pval_q;
  assign finished_o    = pfin_q;
  assign last_o        = plast_q;

endmodule

[test/midpoint_circle_rasterizer_core_tb.sv]
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_core_tb
// Checks the circle rasterizer against a cycle-free model of the midpoint
// loop: directed circles at the coordinate extremes and the origin, then random circles run
// to completion or abandoned, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_core_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = mcr_pkg::DefCoordBits;
  localparam int ColorW = mcr_pkg::ColorBits;
  localparam int NumItems = 310;
  localparam int RadW = CB - 1;
  localparam int PixW = CB + 1;
  localparam int DecW = CB + 2;

  // one result item of the block
  typedef struct packed {
    logic signed [CB:0] x;
    logic signed [CB:0] y;
    logic [ColorW-1:0]  color;
    logic               vld;
    logic               fin;
    logic               lst;
  } pixel_t;

  // tracks the circle state and the pixels still owed by the block
  class circle_tracker;
    logic [ColorW-1:0]     color = mcr_pkg::ColorReset;
    logic signed [CB-1:0]  ctr_x = '0;
    logic signed [CB-1:0]  ctr_y = '0;
    logic [CB-1:0]         col_ofs = '0;
    logic [CB-1:0]         row_ofs = '0;
    logic signed [CB+1:0]  decision = '0;
    logic signed [CB+1:0]  east_step = '0;
    logic signed [CB+1:0]  diag_step = '0;
    logic                  active = 1'b0;
    pixel_t                pending_pixels[$];
    int                    errors = 0;

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // eight symmetric pixels of the current point
    function void push_octants();
      int     dx[8];
      int     dy[8];
      int     i;
      int     j;
      pixel_t p;
      i = int'(col_ofs);
      j = int'(row_ofs);
      dx = '{i, -i, i, -i, j, -j, j, -j};
      dy = '{j, j, -j, -j, i, i, -i, -i};
      for (int k = 0; k < 8; k++) begin
        p.x = PixW'(int'(ctr_x) + dx[k]);
        p.y = PixW'(int'(ctr_y) + dy[k]);
        p.color = color;
        p.vld = 1'b1;
        p.fin = 1'b0;
        p.lst = (k == 7);
        pending_pixels.push_back(p);
      end
    endfunction

    // accepted input item; returns 1 when it finishes the circle
    function bit take_item(logic act, logic signed [CB-1:0] cx,
                           logic signed [CB-1:0] cy, logic [CB-2:0] r);
      pixel_t p;
      if (act == mcr_pkg::ActStart) begin
        ctr_x = cx;
        ctr_y = cy;
        col_ofs = '0;
        row_ofs = CB'(r);
        decision = DecW'(mcr_pkg::DecInitBase - int'(r));
        east_step = DecW'(mcr_pkg::EastInit);
        diag_step = DecW'(mcr_pkg::SeInitBase - 2 * int'(r));
        active = 1'b1;
        push_octants();
        return 1'b0;
      end
      // idle or loop done: one finished result
      if (!active || col_ofs >= row_ofs) begin
        active = 1'b0;
        p = '0;
        p.fin = 1'b1;
        p.lst = 1'b1;
        pending_pixels.push_back(p);
        return 1'b1;
      end
      // one loop step, east or south-east
      if (decision < 0) begin
        decision = decision + east_step;
        east_step = east_step + DecW'(mcr_pkg::EastInc);
        diag_step = diag_step + DecW'(mcr_pkg::EastInc);
      end else begin
        decision = decision + diag_step;
        east_step = east_step + DecW'(mcr_pkg::EastInc);
        diag_step = diag_step + DecW'(mcr_pkg::SeDiagInc);
        row_ofs = row_ofs - 1'b1;
      end
      col_ofs = col_ofs + 1'b1;
      push_octants();
      return 1'b0;
    endfunction

    // accepted result item against the oldest pending one
    task check_pixel(pixel_t got);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        report("result with no item pending");
        return;
      end
      want = pending_pixels.pop_front();
      if (got.x !== want.x)
        report($sformatf("pixel_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        report($sformatf("pixel_y %0d, want %0d", got.y, want.y));
      if (got.color !== want.color)
        report($sformatf("pixel_color %h, want %h", got.color, want.color));
      if (got.vld !== want.vld)
        report($sformatf("pixel_valid %b, want %b", got.vld, want.vld));
      if (got.fin !== want.fin)
        report($sformatf("finished %b, want %b", got.fin, want.fin));
      if (got.lst !== want.lst)
        report($sformatf("last %b, want %b", got.lst, want.lst));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [ColorW-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic action_i;
  logic signed [CB-1:0] center_x_i;
  logic signed [CB-1:0] center_y_i;
  logic [CB-2:0] radius_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [CB:0] pixel_x_o;
  logic signed [CB:0] pixel_y_o;
  logic [ColorW-1:0] pixel_color_o;
  logic pixel_valid_o;
  logic finished_o;
  logic last_o;

  circle_tracker sb = new();
  bit calm = 1'b0;
  int items = 0;

  midpoint_circle_rasterizer_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .action_i      (action_i),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .pixel_valid_o (pixel_valid_o),
    .finished_o    (finished_o),
    .last_o        (last_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // random output stall, none while calm
  always @(posedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(0, 99) < 29);
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_pixel('{pixel_x_o, pixel_y_o, pixel_color_o, pixel_valid_o,
                       finished_o, last_o});
  end

  // drive one input item and wait for it to be taken
  task send_item(input logic act, input logic signed [CB-1:0] cx,
                 input logic signed [CB-1:0] cy, input logic [CB-2:0] r,
                 output bit fin);
    while (!calm && $urandom_range(0, 99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    center_x_i <= cx;
    center_y_i <= cy;
    radius_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    fin = sb.take_item(act, cx, cy, r);
    items++;
  endtask

  task send_advance(output bit fin);
    send_item(mcr_pkg::ActAdvance, CB'($urandom), CB'($urandom), RadW'($urandom), fin);
  endtask

  // start a circle and advance it until finished or max_adv steps
  task run_circle(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
                  input logic [CB-2:0] r, input int max_adv);
    bit fin;
    int n;
    send_item(mcr_pkg::ActStart, cx, cy, r, fin);
    n = 0;
    while (!fin && n < max_adv) begin
      send_advance(fin);
      n++;
    end
  endtask

  // color write once the block has drained
  task write_color(input logic [ColorW-1:0] c);
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= c;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.color = c;
    cfg_valid_i <= 1'b0;
  endtask

  // one random sequence: mostly well-formed circles, some noise
  task random_sequence();
    int kind;
    int r;
    int max_adv;
    bit fin;
    kind = $urandom_range(0, 99);
    if (kind < 6) begin
      send_advance(fin);
    end else if (kind < 10) begin
      send_item(mcr_pkg::ActStart, CB'($urandom), CB'($urandom), RadW'($urandom), fin);
    end else begin
      r = (kind < 22) ? $urandom_range(0, 2047) : $urandom_range(0, 24);
      if (r > 40 || $urandom_range(0, 99) < 15) max_adv = $urandom_range(0, 10);
      else max_adv = 4000;
      run_circle(CB'($urandom), CB'($urandom), RadW'(r), max_adv);
      if ($urandom_range(0, 99) < 10) send_advance(fin);
    end
  endtask

  // stimulus
  initial begin
    bit fin;
    rst_ni <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    action_i <= mcr_pkg::ActStart;
    center_x_i <= '0;
    center_y_i <= '0;
    radius_i <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed circles at the reset color
    send_advance(fin);
    run_circle(-2048, -2048, 0, 4);
    send_advance(fin);
    run_circle(2047, 2047, 2047, 2);
    run_circle(-2048, 2047, 1, 9);
    run_circle(2047, -2048, 2047, 2);
    run_circle(0, 0, 6, 9);

    // random phases with different colors, one without idling
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_color('0);
        2: write_color({ColorW{1'b1}});
        default: write_color(ColorW'($urandom));
      endcase
      calm = (ph == 1);
      while (items < (ph + 1) * (NumItems / 4)) random_sequence();
    end
    calm = 1'b0;

    // drain
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // timeout
  initial begin
    #3ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/mcr_pkg.sv
rtl/mcr_ctrl.sv
rtl/mcr_datapath.sv
rtl/midpoint_circle_rasterizer_core.sv
test/midpoint_circle_rasterizer_core_tb.sv
